// ----- sv/rscp_pkg.sv -----
// ----------------------------------------------------------------------------
// rscp_pkg
// Shared types and constants for the ray segment crossing parity core.
// ----------------------------------------------------------------------------
package rscp_pkg;

	localparam int LIMIT_BITS   = 16;
	localparam int CFG_IDX_BITS = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_THROUGH_X = 3'd2,
		REG_THROUGH_Y = 3'd3,
		REG_PAR_LIMIT = 3'd4
	} cfg_idx_t;

	// what the crossing pipe hands to the counter stage
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} rscp_tail_t;

endpackage

// ----- sv/rscp_hit_pipe.sv -----
// ----------------------------------------------------------------------------
// rscp_hit_pipe
// Four-stage crossing test: input word, differences, products,
// cross products; the hit decision is taken from the last stage.
// ----------------------------------------------------------------------------
module rscp_hit_pipe #(
	parameter int COORD_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_take,
	input  logic signed [COORD_BITS-1:0]        seg_start_x,
	input  logic signed [COORD_BITS-1:0]        seg_start_y,
	input  logic signed [COORD_BITS-1:0]        seg_end_x,
	input  logic signed [COORD_BITS-1:0]        seg_end_y,
	input  logic                                last_segment,
	input  logic signed [COORD_BITS-1:0]        origin_x,
	input  logic signed [COORD_BITS-1:0]        origin_y,
	input  logic signed [COORD_BITS-1:0]        through_x,
	input  logic signed [COORD_BITS-1:0]        through_y,
	input  logic [rscp_pkg::LIMIT_BITS-1:0]     par_limit,
	output rscp_pkg::rscp_tail_t                tail
);
	import rscp_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int P = 2 * D;
	localparam int W = P + 1;

	// stage 1: raw word
	logic                         v_s1, last_s1;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	// stage 2: differences
	logic                         v_s2, last_s2;
	logic signed [D-1:0]          dx_s2, dy_s2, ex_s2, ey_s2, rx_s2, ry_s2;
	// stage 3: products
	logic                         v_s3, last_s3;
	logic signed [P-1:0]          p_dxey_s3, p_dyex_s3, p_dyrx_s3;
	logic signed [P-1:0]          p_dxry_s3, p_eyrx_s3, p_exry_s3;
	// stage 4: cross products
	logic                         v_s4, last_s4;
	logic signed [W-1:0]          m_s4, nt_s4, ns_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= seg_start_x;
			ay_s1   <= seg_start_y;
			bx_s1   <= seg_end_x;
			by_s1   <= seg_end_y;
			last_s1 <= last_segment;

			dx_s2   <= D'(through_x) - D'(origin_x);
			dy_s2   <= D'(through_y) - D'(origin_y);
			ex_s2   <= D'(bx_s1) - D'(ax_s1);
			ey_s2   <= D'(by_s1) - D'(ay_s1);
			rx_s2   <= D'(ax_s1) - D'(origin_x);
			ry_s2   <= D'(ay_s1) - D'(origin_y);
			last_s2 <= last_s1;

			p_dxey_s3 <= P'(dx_s2) * P'(ey_s2);
			p_dyex_s3 <= P'(dy_s2) * P'(ex_s2);
			p_dyrx_s3 <= P'(dy_s2) * P'(rx_s2);
			p_dxry_s3 <= P'(dx_s2) * P'(ry_s2);
			p_eyrx_s3 <= P'(ey_s2) * P'(rx_s2);
			p_exry_s3 <= P'(ex_s2) * P'(ry_s2);
			last_s3   <= last_s2;

			m_s4    <= W'(p_dxey_s3) - W'(p_dyex_s3);
			nt_s4   <= W'(p_dyrx_s3) - W'(p_dxry_s3);
			ns_s4   <= W'(p_eyrx_s3) - W'(p_exry_s3);
			last_s4 <= last_s3;
		end
	end

	// hit decision: t = nt/m in [0,1), s = ns/m >= 0, without dividing
	logic signed [W-1:0] lim_w;
	logic                near_par, m_neg, hit_pos, hit_neg;

	always_comb begin
		lim_w    = W'($signed({1'b0, par_limit}));
		near_par = (m_s4 <= lim_w) && (m_s4 >= -lim_w);
		m_neg    = m_s4[W-1];
		hit_pos  = !nt_s4[W-1] && (nt_s4 < m_s4) && !ns_s4[W-1];
		hit_neg  = (nt_s4[W-1] || (nt_s4 == '0)) && (m_s4 < nt_s4) &&
			(ns_s4[W-1] || (ns_s4 == '0));
		tail.valid = v_s4;
		tail.last  = last_s4;
		tail.hit   = !near_par && (m_neg ? hit_neg : hit_pos);
	end

endmodule

// ----- sv/ray_segment_crossing_parity_core.sv -----
// ----------------------------------------------------------------------------
// ray_segment_crossing_parity_core
// Even-odd ray crossing counter over a stream of outline segments.
// ----------------------------------------------------------------------------
// throughput: one segment per cycle while in_stall is low; the crossing test is a 4-stage pipe
// in_stall rises only while the final stage holds a last segment and the
// result register is full and stalled
// reset clears configuration to zero, the crossing count, parity and valids
module ray_segment_crossing_parity_core #(
	parameter int COORD_BITS = 24,
	parameter int COUNT_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [rscp_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [((COORD_BITS > rscp_pkg::LIMIT_BITS) ?
		COORD_BITS : rscp_pkg::LIMIT_BITS)-1:0]      cfg_wdata,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [COORD_BITS-1:0]             seg_start_x,
	input  logic signed [COORD_BITS-1:0]             seg_start_y,
	input  logic signed [COORD_BITS-1:0]             seg_end_x,
	input  logic signed [COORD_BITS-1:0]             seg_end_y,
	input  logic                                     last_segment,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     is_hole,
	output logic [COUNT_BITS-1:0]                    crossing_total
);
	import rscp_pkg::*;

	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, through_x_q, through_y_q;
	logic [LIMIT_BITS-1:0]        limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			through_x_q <= '0;
			through_y_q <= '0;
			limit_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  origin_x_q  <= cfg_wdata[COORD_BITS-1:0];
				REG_ORIGIN_Y:  origin_y_q  <= cfg_wdata[COORD_BITS-1:0];
				REG_THROUGH_X: through_x_q <= cfg_wdata[COORD_BITS-1:0];
				REG_THROUGH_Y: through_y_q <= cfg_wdata[COORD_BITS-1:0];
				REG_PAR_LIMIT: limit_q     <= cfg_wdata[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	rscp_tail_t tail;
	logic       adv, in_take;
	logic       out_valid_q, is_hole_q, parity_q;
	logic [COUNT_BITS-1:0] count_q, total_q;
	logic [COUNT_BITS-1:0] count_nx;
	logic                  parity_nx;

	// the pipe halts only when a finished test cannot be handed out
	assign adv      = !(tail.valid && tail.last && out_valid_q && out_stall);
	assign in_stall = !adv;
	assign in_take  = in_valid && adv;

	rscp_hit_pipe #(
		.COORD_BITS (COORD_BITS)
	) u_hit_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_take      (in_take),
		.seg_start_x  (seg_start_x),
		.seg_start_y  (seg_start_y),
		.seg_end_x    (seg_end_x),
		.seg_end_y    (seg_end_y),
		.last_segment (last_segment),
		.origin_x     (origin_x_q),
		.origin_y     (origin_y_q),
		.through_x    (through_x_q),
		.through_y    (through_y_q),
		.par_limit    (limit_q),
		.tail         (tail)
	);

	// saturating count, parity of the true count
	always_comb begin
		count_nx  = count_q;
		parity_nx = parity_q;
		if (tail.hit) begin
			parity_nx = !parity_q;
			if (count_q != '1) begin
				count_nx = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && tail.valid && tail.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv && tail.valid) begin
				if (tail.last) begin
					count_q  <= '0;
					parity_q <= 1'b0;
				end else begin
					count_q  <= count_nx;
					parity_q <= parity_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.valid && tail.last) begin
			is_hole_q <= parity_nx;
			total_q   <= count_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign is_hole        = is_hole_q;
	assign crossing_total = total_q;

	// a result word appears only after a last segment left the pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && tail.valid && tail.last))
		else $error("result word without a last segment");

	// below saturation the parity must follow the count
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (total_q != '1)) |-> (is_hole_q == total_q[0]))
		else $error("parity and crossing count disagree");

	// input is held off only by a stalled full result register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without output back-pressure");

	// the count is clear right after a result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv && tail.valid && tail.last) |-> (count_q == '0 && !parity_q))
		else $error("counter not cleared after a test");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_segment_crossing_parity_core: drives segment
// words and register writes, keeps an even-odd crossing predictor in a small
// scoreboard and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import rscp_pkg::*;

	localparam int COORD_BITS = 24;
	localparam int COUNT_BITS = 16;
	localparam int CFG_W = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
	localparam longint ONE = 256;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int PIPE_LATENCY = 4;
	localparam int HOLD_CYCLES = 150;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int RUN_LIMIT_NS = 10_000_000;

	class crossing_scoreboard;
		typedef struct {
			logic                  hole;
			logic [COUNT_BITS-1:0] total;
		} verdict_t;

		logic signed [COORD_BITS-1:0] origin_x, origin_y, through_x, through_y;
		logic [LIMIT_BITS-1:0]        parallel_limit;
		logic [COUNT_BITS-1:0]        crossing_count;
		logic                         parity;
		verdict_t                     expected_verdicts[$];
		int                           errors;

		function new();
			origin_x = '0;
			origin_y = '0;
			through_x = '0;
			through_y = '0;
			parallel_limit = '0;
			crossing_count = '0;
			parity = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ORIGIN_X: origin_x = data[COORD_BITS-1:0];
				REG_ORIGIN_Y: origin_y = data[COORD_BITS-1:0];
				REG_THROUGH_X: through_x = data[COORD_BITS-1:0];
				REG_THROUGH_Y: through_y = data[COORD_BITS-1:0];
				REG_PAR_LIMIT: parallel_limit = data[LIMIT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// t = tnum/det in [0,1) and s = snum/det >= 0, without dividing
		function bit segment_crosses(logic signed [COORD_BITS-1:0] sx, sy, ex, ey);
			longint dx, dy, ux, uy, rx, ry, det, tnum, snum, mag, lim;
			dx = longint'(through_x) - longint'(origin_x);
			dy = longint'(through_y) - longint'(origin_y);
			ux = longint'(ex) - longint'(sx);
			uy = longint'(ey) - longint'(sy);
			rx = longint'(sx) - longint'(origin_x);
			ry = longint'(sy) - longint'(origin_y);
			det = dx * uy - dy * ux;
			tnum = dy * rx - dx * ry;
			snum = uy * rx - ux * ry;
			mag = (det < 0) ? -det : det;
			lim = parallel_limit;
			if (mag <= lim)
				return 1'b0;
			if (det > 0)
				return (tnum >= 0) && (tnum < det) && (snum >= 0);
			return (tnum <= 0) && (tnum > det) && (snum <= 0);
		endfunction

		function void note_segment(logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
				logic is_last);
			verdict_t v;
			if (segment_crosses(sx, sy, ex, ey)) begin
				if (crossing_count != '1)
					crossing_count++;
				parity = ~parity;
			end
			if (is_last) begin
				v.hole = parity;
				v.total = crossing_count;
				expected_verdicts.push_back(v);
				crossing_count = '0;
				parity = 1'b0;
			end
		endfunction

		function void check_result(logic hole, logic [COUNT_BITS-1:0] total);
			verdict_t want;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: result word with nothing expected: is_hole %0b crossing_total %0d",
					$time, hole, total);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			if (hole !== want.hole) begin
				$display("%0t: is_hole mismatch: expected %0b actual %0b",
					$time, want.hole, hole);
				errors++;
			end
			if (total !== want.total) begin
				$display("%0t: crossing_total mismatch: expected %0d actual %0d",
					$time, want.total, total);
				errors++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_IDX_BITS-1:0]      cfg_index;
	logic [CFG_W-1:0]             cfg_wdata;
	logic                         in_valid;
	logic                         in_stall;
	logic signed [COORD_BITS-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic                         last_segment;
	logic                         out_valid;
	logic                         out_stall;
	logic                         is_hole;
	logic [COUNT_BITS-1:0]        crossing_total;

	crossing_scoreboard sb;
	bit sender_eager = 1'b0;
	bit hold_req = 1'b0;

	ray_segment_crossing_parity_core #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.seg_start_x(seg_start_x),
		.seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x),
		.seg_end_y(seg_end_y),
		.last_segment(last_segment),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_hole(is_hole),
		.crossing_total(crossing_total)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(25, 60);
	endfunction

	function automatic longint rand_within(longint span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] to_coord(longint v);
		if (v > COORD_MAX)
			return COORD_BITS'(COORD_MAX);
		if (v < COORD_MIN)
			return COORD_BITS'(COORD_MIN);
		return COORD_BITS'(v);
	endfunction

	function automatic int test_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(1, 4);
		if (r < 9)
			return $urandom_range(5, 16);
		return $urandom_range(17, 60);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// limit word carries random junk above its 16 bits
	task automatic set_ray(input longint ox, oy, tx, ty, input int limit);
		cfg_write(REG_ORIGIN_X, to_coord(ox));
		cfg_write(REG_ORIGIN_Y, to_coord(oy));
		cfg_write(REG_THROUGH_X, to_coord(tx));
		cfg_write(REG_THROUGH_Y, to_coord(ty));
		cfg_write(REG_PAR_LIMIT, {(CFG_W - LIMIT_BITS)'($urandom), LIMIT_BITS'(limit)});
		end_writes();
	endtask

	task automatic send_segment(input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
			input logic is_last);
		int gap;
		gap = sender_eager ? 0 : idle_span();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		seg_start_x <= sx;
		seg_start_y <= sy;
		seg_end_x <= ex;
		seg_end_y <= ey;
		last_segment <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_segment(sx, sy, ex, ey, is_last);
	endtask

	task automatic send_pts(input longint sx, sy, ex, ey, input logic is_last);
		send_segment(to_coord(sx), to_coord(sy), to_coord(ex), to_coord(ey), is_last);
	endtask

	// every test ends on a last segment, so an empty queue plus the pipe depth means idle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic make_segment(output logic signed [COORD_BITS-1:0] sx, sy, ex, ey);
		longint ox, oy, dx, dy, qx, qy, a0, b0, a1, b1, span, cx, cy;
		int pick;
		ox = sb.origin_x;
		oy = sb.origin_y;
		dx = longint'(sb.through_x) - ox;
		dy = longint'(sb.through_y) - oy;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			// lattice on the ray direction: endpoints can land on the ray line and the origin
			qx = rand_within(longint'(1) << $urandom_range(0, 10));
			qy = rand_within(longint'(1) << $urandom_range(0, 10));
			a0 = longint'($urandom_range(0, 6)) - 3;
			b0 = longint'($urandom_range(0, 4)) - 2;
			a1 = longint'($urandom_range(0, 6)) - 3;
			b1 = longint'($urandom_range(0, 4)) - 2;
			sx = to_coord(ox + a0 * dx + b0 * qx);
			sy = to_coord(oy + a0 * dy + b0 * qy);
			ex = to_coord(ox + a1 * dx + b1 * qx);
			ey = to_coord(oy + a1 * dy + b1 * qy);
		end else if (pick < 65) begin
			span = longint'(1) << $urandom_range(2, 18);
			sx = to_coord(ox + rand_within(span));
			sy = to_coord(oy + rand_within(span));
			ex = to_coord(ox + rand_within(span));
			ey = to_coord(oy + rand_within(span));
		end else if (pick < 80) begin
			sx = COORD_BITS'($urandom);
			sy = COORD_BITS'($urandom);
			ex = COORD_BITS'($urandom);
			ey = COORD_BITS'($urandom);
		end else begin
			// nearly parallel to the ray, cross product close to the limit
			cx = ox + rand_within(1 << 12);
			cy = oy + rand_within(1 << 12);
			a0 = $urandom_range(1, 3);
			sx = to_coord(cx);
			sy = to_coord(cy);
			ex = to_coord(cx + a0 * dx + longint'($urandom_range(0, 4)) - 2);
			ey = to_coord(cy + a0 * dy + longint'($urandom_range(0, 4)) - 2);
		end
	endtask

	task automatic directed_checks();
		int k;
		// registers still at reset: zero-length ray never counts
		send_pts(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
		wait_idle();
		set_ray(0, 0, ONE, 0, 0);
		send_pts(2 * ONE, -ONE, 2 * ONE, ONE, 1'b0);
		send_pts(2 * ONE, 0, 2 * ONE, ONE, 1'b0);         // starts on the ray
		send_pts(3 * ONE, -ONE, 3 * ONE, 0, 1'b0);        // ends on the ray
		send_pts(0, -ONE, 0, ONE, 1'b0);                  // through the origin
		send_pts(-2 * ONE, -ONE, -2 * ONE, ONE, 1'b0);    // behind the origin
		send_pts(0, ONE, 4 * ONE, ONE, 1'b0);             // parallel
		send_pts(0, 0, 4 * ONE, 0, 1'b0);                 // on the ray line
		send_pts(2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b0); // zero length
		send_pts(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
		send_pts(2 * ONE, ONE, 2 * ONE, -ONE, 1'b0);      // reversed direction
		send_pts(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);
		wait_idle();
		set_ray(0, 0, ONE, 0, 16'hFFFF);
		// writes past the last register must not land anywhere
		for (k = 1; k <= 3; k++)
			cfg_write(CFG_IDX_BITS'(REG_PAR_LIMIT + k), CFG_W'($urandom));
		end_writes();
		send_pts(2 * ONE, -128, 2 * ONE, 127, 1'b0);      // cross just under the limit
		send_pts(2 * ONE, -128, 2 * ONE, 128, 1'b1);      // just above
		send_pts(2 * ONE, -ONE, 2 * ONE, ONE, 1'b1);
	endtask

	task automatic pick_ray(input int phase);
		longint ox, oy;
		ox = rand_within(1 << 10);
		oy = rand_within(1 << 10);
		case (phase)
			0: set_ray(ox, oy, ox + rand_within(64), oy + rand_within(64), 0);
			1: set_ray(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'hFFFF);
			2: set_ray(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, $urandom_range(0, 65535));
			3: begin
				if ($urandom_range(0, 1))
					set_ray(ox, oy, ox + ($urandom_range(0, 1) ? ONE : -ONE), oy, 0);
				else
					set_ray(ox, oy, ox, oy + ($urandom_range(0, 1) ? ONE : -ONE), 0);
			end
			4: begin
				ox = rand_within(1 << 20);
				oy = rand_within(1 << 20);
				set_ray(ox, oy, ox + rand_within(longint'(1) << $urandom_range(0, 14)),
					oy + rand_within(longint'(1) << $urandom_range(0, 14)),
					$urandom_range(0, 1023));
			end
			5: set_ray(rand_within(COORD_MAX), rand_within(COORD_MAX), rand_within(COORD_MAX),
				rand_within(COORD_MAX), $urandom_range(0, 65535));
			6: set_ray(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0);
			default: set_ray(ox, oy, ox + rand_within(64), oy + rand_within(64),
				$urandom_range(0, 200));
		endcase
	endtask

	initial begin : stimulus
		int phase, sent, len, k;
		logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		seg_start_x = '0;
		seg_start_y = '0;
		seg_end_x = '0;
		seg_end_y = '0;
		last_segment = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_checks();

		for (phase = 0; phase < N_PHASES; phase++) begin
			wait_idle();
			pick_ray(phase);
			sent = 0;
			if (phase == 3) begin
				// sink holds off while short tests keep coming, so the core must back up
				hold_req = 1'b1;
				sender_eager = 1'b1;
				for (k = 0; k < 48; k++) begin
					make_segment(sx, sy, ex, ey);
					send_segment(sx, sy, ex, ey, k[0]);
				end
				sender_eager = 1'b0;
				sent = 48;
			end
			while (sent < ITEMS_PER_PHASE) begin
				len = test_length();
				sender_eager = ($urandom_range(0, 3) == 0);
				for (k = 0; k < len; k++) begin
					make_segment(sx, sy, ex, ey);
					send_segment(sx, sy, ex, ey, k == len - 1);
				end
				sent += len;
				if ($urandom_range(0, 15) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : result_sink
		int stall_left, free_left, hold_left;
		out_stall = 1'b0;
		stall_left = 0;
		free_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (free_left > 0)
					free_left--;
				else begin
					stall_left = idle_span();
					free_left = ($urandom_range(0, 9) == 0) ?
						$urandom_range(30, 80) : $urandom_range(0, 4);
				end
			end
		end
	end

	// result word taken on this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(is_hole, crossing_total);
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
